@@ rtl/qvr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion vector rotation package
// Shared widths, default parameter values and register indexes.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int COORD_WIDTH_DEF    = 16;
  localparam int QUAT_FRAC_BITS_DEF = 14;

  localparam int QUAT_W  = 16;
  localparam int QPROD_W = 2 * QUAT_W;
  localparam int MAT_W   = QPROD_W + 2;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  typedef enum logic [1:0] {
    REG_QUAT_W = 2'd0,
    REG_QUAT_X = 2'd1,
    REG_QUAT_Y = 2'd2,
    REG_QUAT_Z = 2'd3
  } reg_idx_e;

endpackage
`default_nettype wire

@@ rtl/quaternion_vector_rotate_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion vector rotation core
// Rotates each input vector by the quaternion held in four APB registers,
// then rounds, shifts and saturates each coordinate.
// ----------------------------------------------------------------------------
// Usage:
//   The quaternion (w, x, y, z) in Q2.14 is written through the APB port at
//   byte addresses 0, 4, 8 and 12; the user must write it only while no vector
//   is in flight, as the block does not enforce this. Each vec input beat
//   carries one vector; each rot output beat, the rotated vector and a saturation flag.
//   The datapath is a five-stage pipeline: quaternion products, rotation
//   matrix, nine coordinate products, row sums with rounding, then shift and
//   saturation into the output register. One beat per cycle is sustained while
//   rot_ready_i stays high.
//   Each stage advances when it is empty or the next stage advances, so a
//   stall on rot_ready_i fills the bubbles first and then holds every stage
//   in place; vec_ready_o drops only when all five stages are full.
//   Reset empties the pipeline and loads the identity quaternion.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_core
  import qvr_pkg::*;
#(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ADDR_W-1:0]             paddr,
  input  wire logic [DATA_W-1:0]             pwdata,
  output logic      [DATA_W-1:0]             prdata,
  output logic                               pready,
  input  wire logic                          vec_valid_i,
  output logic                               vec_ready_o,
  input  wire logic signed [COORD_WIDTH-1:0] vec_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] vec_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] vec_z_i,
  output logic                               rot_valid_o,
  input  wire logic                          rot_ready_i,
  output logic signed [COORD_WIDTH+1:0]      rot_x_o,
  output logic signed [COORD_WIDTH+1:0]      rot_y_o,
  output logic signed [COORD_WIDTH+1:0]      rot_z_o,
  output logic                               saturated_o
);

  localparam int OUT_W  = COORD_WIDTH + 2;
  localparam int MUL_W  = MAT_W + COORD_WIDTH;
  localparam int SHIFT  = 2 * QUAT_FRAC_BITS;
  localparam int SUM_W  = (MUL_W + 2 > SHIFT + 2) ? MUL_W + 2 : SHIFT + 2;
  localparam int STAGES = 5;

  localparam logic [QUAT_W-1:0] QUAT_ONE =
    (QUAT_FRAC_BITS < QUAT_W) ? (QUAT_W'(1) << QUAT_FRAC_BITS) : '0;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (SHIFT - 1);
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Configuration registers.
  logic signed [QUAT_W-1:0] quat_w_q, quat_x_q, quat_y_q, quat_z_q;
  logic                     cfg_wr;
  reg_idx_e                 cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_w_q <= QUAT_ONE;
      quat_x_q <= '0;
      quat_y_q <= '0;
      quat_z_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_QUAT_W: quat_w_q <= pwdata[QUAT_W-1:0];
        REG_QUAT_X: quat_x_q <= pwdata[QUAT_W-1:0];
        REG_QUAT_Y: quat_y_q <= pwdata[QUAT_W-1:0];
        REG_QUAT_Z: quat_z_q <= pwdata[QUAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_QUAT_W: prdata = {{(DATA_W-QUAT_W){1'b0}}, quat_w_q};
      REG_QUAT_X: prdata = {{(DATA_W-QUAT_W){1'b0}}, quat_x_q};
      REG_QUAT_Y: prdata = {{(DATA_W-QUAT_W){1'b0}}, quat_y_q};
      REG_QUAT_Z: prdata = {{(DATA_W-QUAT_W){1'b0}}, quat_z_q};
      default:    prdata = '0;
    endcase
  end

  // Stage control.
  logic [STAGES-1:0] vld_q;
  logic [STAGES-1:0] stg_en;

  always_comb begin
    stg_en[STAGES-1] = ~vld_q[STAGES-1] | rot_ready_i;
    for (int k = STAGES - 2; k >= 0; k--) begin
      stg_en[k] = ~vld_q[k] | stg_en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (stg_en[0]) begin
        vld_q[0] <= vec_valid_i;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (stg_en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign vec_ready_o = stg_en[0];
  assign rot_valid_o = vld_q[STAGES-1];

  // Stage 1: the ten quaternion component products.
  logic signed [QPROD_W-1:0] ww_q, xx_q, yy_q, zz_q, wx_q, wy_q, wz_q, xy_q, xz_q, yz_q;
  logic signed [COORD_WIDTH-1:0] vec_s1_q [3];

  always_ff @(posedge clk_i) begin
    if (stg_en[0]) begin
      ww_q        <= QPROD_W'(quat_w_q) * QPROD_W'(quat_w_q);
      xx_q        <= QPROD_W'(quat_x_q) * QPROD_W'(quat_x_q);
      yy_q        <= QPROD_W'(quat_y_q) * QPROD_W'(quat_y_q);
      zz_q        <= QPROD_W'(quat_z_q) * QPROD_W'(quat_z_q);
      wx_q        <= QPROD_W'(quat_w_q) * QPROD_W'(quat_x_q);
      wy_q        <= QPROD_W'(quat_w_q) * QPROD_W'(quat_y_q);
      wz_q        <= QPROD_W'(quat_w_q) * QPROD_W'(quat_z_q);
      xy_q        <= QPROD_W'(quat_x_q) * QPROD_W'(quat_y_q);
      xz_q        <= QPROD_W'(quat_x_q) * QPROD_W'(quat_z_q);
      yz_q        <= QPROD_W'(quat_y_q) * QPROD_W'(quat_z_q);
      vec_s1_q[0] <= vec_x_i;
      vec_s1_q[1] <= vec_y_i;
      vec_s1_q[2] <= vec_z_i;
    end
  end

  // Stage 2: rotation matrix.
  logic signed [MAT_W-1:0] e_ww, e_xx, e_yy, e_zz, e_wx, e_wy, e_wz, e_xy, e_xz, e_yz;
  logic signed [MAT_W-1:0] mat_d [3][3];
  logic signed [MAT_W-1:0] mat_q [3][3];
  logic signed [COORD_WIDTH-1:0] vec_s2_q [3];

  always_comb begin
    e_ww = MAT_W'(ww_q);
    e_xx = MAT_W'(xx_q);
    e_yy = MAT_W'(yy_q);
    e_zz = MAT_W'(zz_q);
    e_wx = MAT_W'(wx_q);
    e_wy = MAT_W'(wy_q);
    e_wz = MAT_W'(wz_q);
    e_xy = MAT_W'(xy_q);
    e_xz = MAT_W'(xz_q);
    e_yz = MAT_W'(yz_q);
    mat_d[0][0] = e_ww + e_xx - e_yy - e_zz;
    mat_d[0][1] = (e_xy - e_wz) <<< 1;
    mat_d[0][2] = (e_xz + e_wy) <<< 1;
    mat_d[1][0] = (e_xy + e_wz) <<< 1;
    mat_d[1][1] = e_ww - e_xx + e_yy - e_zz;
    mat_d[1][2] = (e_yz - e_wx) <<< 1;
    mat_d[2][0] = (e_xz - e_wy) <<< 1;
    mat_d[2][1] = (e_yz + e_wx) <<< 1;
    mat_d[2][2] = e_ww - e_xx - e_yy + e_zz;
  end

  always_ff @(posedge clk_i) begin
    if (stg_en[1]) begin
      mat_q    <= mat_d;
      vec_s2_q <= vec_s1_q;
    end
  end

  // Stage 3: nine matrix by coordinate products.
  logic signed [MUL_W-1:0] mul_q [3][3];

  always_ff @(posedge clk_i) begin
    if (stg_en[2]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          mul_q[r][c] <= MUL_W'(mat_q[r][c]) * MUL_W'(vec_s2_q[c]);
        end
      end
    end
  end

  // Stage 4: row sums with the rounding half added.
  logic signed [SUM_W-1:0] sum_q [3];

  always_ff @(posedge clk_i) begin
    if (stg_en[3]) begin
      for (int r = 0; r < 3; r++) begin
        sum_q[r] <= SUM_W'(mul_q[r][0]) + SUM_W'(mul_q[r][1]) + SUM_W'(mul_q[r][2])
                    + ROUND_HALF;
      end
    end
  end

  // Stage 5: shift, saturate and register the result.
  logic signed [SUM_W-1:0]       shf [3];
  logic signed [OUT_W-1:0]       res_d [3];
  logic [2:0]                    clip;
  logic signed [OUT_W-1:0]       rot_q [3];
  logic                          sat_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      shf[r] = sum_q[r] >>> SHIFT;
      if (!shf[r][SUM_W-1] && (|shf[r][SUM_W-1:OUT_W-1])) begin
        res_d[r] = OUT_MAX;
        clip[r]  = 1'b1;
      end else if (shf[r][SUM_W-1] && !(&shf[r][SUM_W-1:OUT_W-1])) begin
        res_d[r] = OUT_MIN;
        clip[r]  = 1'b1;
      end else begin
        res_d[r] = shf[r][OUT_W-1:0];
        clip[r]  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_en[4]) begin
      rot_q <= res_d;
      sat_q <= |clip;
    end
  end

  assign rot_x_o     = rot_q[0];
  assign rot_y_o     = rot_q[1];
  assign rot_z_o     = rot_q[2];
  assign saturated_o = sat_q;

endmodule
`default_nettype wire

@@ rtl/qvr_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion vector rotation port checker
// Watches the top level's ports and flags behavior that breaks the block's
// contract.
// ----------------------------------------------------------------------------
module qvr_checker
  import qvr_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          psel,
  input wire logic                          penable,
  input wire logic                          pwrite,
  input wire logic [ADDR_W-1:0]             paddr,
  input wire logic [DATA_W-1:0]             pwdata,
  input wire logic [DATA_W-1:0]             prdata,
  input wire logic                          pready,
  input wire logic                          vec_ready_o,
  input wire logic                          rot_valid_o,
  input wire logic                          rot_ready_i,
  input wire logic signed [COORD_WIDTH+1:0] rot_x_o,
  input wire logic signed [COORD_WIDTH+1:0] rot_y_o,
  input wire logic signed [COORD_WIDTH+1:0] rot_z_o,
  input wire logic                          saturated_o
);

  localparam int OUT_W = COORD_WIDTH + 2;
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // A beat that waits keeps its payload.
  a_rot_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot_valid_o && !rot_ready_i |=> rot_valid_o && $stable(rot_x_o)
      && $stable(rot_y_o) && $stable(rot_z_o) && $stable(saturated_o))
    else $error("rot beat changed while stalled");

  // A saturated beat has at least one coordinate at a range limit.
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot_valid_o && saturated_o |->
      rot_x_o == OUT_MAX || rot_x_o == OUT_MIN || rot_y_o == OUT_MAX
      || rot_y_o == OUT_MIN || rot_z_o == OUT_MAX || rot_z_o == OUT_MIN)
    else $error("saturation flag without a clipped coordinate");

  // With no result waiting, the pipeline has room for a new beat.
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rot_valid_o |-> vec_ready_o)
    else $error("input stalled while output is empty");

  // A register read right after a write to it returns the written value.
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready |=>
      !(psel && !pwrite && paddr[3:2] == $past(paddr[3:2]))
      || prdata[15:0] == $past(pwdata[15:0]))
    else $error("register readback mismatch");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind quaternion_vector_rotate_core qvr_checker #(
  .COORD_WIDTH(COORD_WIDTH)
) u_qvr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .pready      (pready),
  .vec_ready_o (vec_ready_o),
  .rot_valid_o (rot_valid_o),
  .rot_ready_i (rot_ready_i),
  .rot_x_o     (rot_x_o),
  .rot_y_o     (rot_y_o),
  .rot_z_o     (rot_z_o),
  .saturated_o (saturated_o)
);
`default_nettype wire

@@ tb/sv/rot_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion rotation result checker
// Follows the quaternion registers through the APB writes and computes each
// rotated vector as every vec beat is taken. It then compares every rot beat,
// field by field, with the oldest rotated vector still waiting.
// ----------------------------------------------------------------------------
module rot_checker
  import qvr_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [ADDR_W-1:0]             paddr_i,
  input  logic [DATA_W-1:0]             pwdata_i,
  input  logic                          pready_i,
  input  logic                          vec_valid_i,
  input  logic                          vec_ready_i,
  input  logic signed [COORD_WIDTH_DEF-1:0] vec_x_i,
  input  logic signed [COORD_WIDTH_DEF-1:0] vec_y_i,
  input  logic signed [COORD_WIDTH_DEF-1:0] vec_z_i,
  input  logic                          rot_valid_i,
  input  logic                          rot_ready_i,
  input  logic signed [COORD_WIDTH_DEF+1:0] rot_x_i,
  input  logic signed [COORD_WIDTH_DEF+1:0] rot_y_i,
  input  logic signed [COORD_WIDTH_DEF+1:0] rot_z_i,
  input  logic                          saturated_i,
  output int unsigned                   err_count_o,
  output int unsigned                   pending_o
);

  localparam int     CW      = COORD_WIDTH_DEF;
  localparam int     OW      = CW + 2;
  localparam int     SHIFT   = 2 * QUAT_FRAC_BITS_DEF;
  localparam longint OUT_MAX = (longint'(1) << (OW - 1)) - 1;
  localparam longint OUT_MIN = -OUT_MAX - 1;

  typedef struct packed {
    logic signed [OW-1:0] x;
    logic signed [OW-1:0] y;
    logic signed [OW-1:0] z;
    logic                 sat;
  } rot_beat_t;

  logic signed [QUAT_W-1:0] q_w;
  logic signed [QUAT_W-1:0] q_x;
  logic signed [QUAT_W-1:0] q_y;
  logic signed [QUAT_W-1:0] q_z;
  rot_beat_t                rotated_vec_q[$];
  int unsigned              rot_beat_cnt;

  task automatic report_mismatch(input string msg);
    err_count_o++;
    $display("ERROR: rot beat %0d: %s", rot_beat_cnt, msg);
  endtask

  function automatic logic signed [OW-1:0] round_and_clip(input longint acc,
                                                          inout logic sat);
    longint r;
    r = (acc + (longint'(1) << (SHIFT - 1))) >>> SHIFT;
    if (r > OUT_MAX) begin
      r   = OUT_MAX;
      sat = 1'b1;
    end else if (r < OUT_MIN) begin
      r   = OUT_MIN;
      sat = 1'b1;
    end
    return OW'(r);
  endfunction

  function automatic rot_beat_t rotate_vector(input logic signed [CW-1:0] vx,
                                              input logic signed [CW-1:0] vy,
                                              input logic signed [CW-1:0] vz);
    longint    w, x, y, z;
    longint    ww, xx, yy, zz, wx, wy, wz, xy, xz, yz;
    longint    m[3][3];
    longint    v[3];
    logic      sat;
    rot_beat_t r;
    w  = longint'(q_w);
    x  = longint'(q_x);
    y  = longint'(q_y);
    z  = longint'(q_z);
    ww = w * w;
    xx = x * x;
    yy = y * y;
    zz = z * z;
    wx = w * x;
    wy = w * y;
    wz = w * z;
    xy = x * y;
    xz = x * z;
    yz = y * z;
    m[0][0] = ww + xx - yy - zz;
    m[0][1] = 2 * (xy - wz);
    m[0][2] = 2 * (xz + wy);
    m[1][0] = 2 * (xy + wz);
    m[1][1] = ww - xx + yy - zz;
    m[1][2] = 2 * (yz - wx);
    m[2][0] = 2 * (xz - wy);
    m[2][1] = 2 * (yz + wx);
    m[2][2] = ww - xx - yy + zz;
    v[0] = longint'(vx);
    v[1] = longint'(vy);
    v[2] = longint'(vz);
    sat  = 1'b0;
    r.x  = round_and_clip(m[0][0] * v[0] + m[0][1] * v[1] + m[0][2] * v[2], sat);
    r.y  = round_and_clip(m[1][0] * v[0] + m[1][1] * v[1] + m[1][2] * v[2], sat);
    r.z  = round_and_clip(m[2][0] * v[0] + m[2][1] * v[1] + m[2][2] * v[2], sat);
    r.sat = sat;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rot_beat_t want;
    if (!rst_ni) begin
      q_w          = QUAT_W'(1 << QUAT_FRAC_BITS_DEF);
      q_x          = '0;
      q_y          = '0;
      q_z          = '0;
      rotated_vec_q.delete();
      rot_beat_cnt = 0;
      err_count_o  = 0;
    end else begin
      if (rot_valid_i && rot_ready_i) begin
        if (rotated_vec_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat (%0d, %0d, %0d, sat %0b)",
                                    rot_x_i, rot_y_i, rot_z_i, saturated_i));
        end else begin
          want = rotated_vec_q.pop_front();
          if (rot_x_i !== want.x) begin
            report_mismatch($sformatf("rot_x got %0d, want %0d", rot_x_i, want.x));
          end
          if (rot_y_i !== want.y) begin
            report_mismatch($sformatf("rot_y got %0d, want %0d", rot_y_i, want.y));
          end
          if (rot_z_i !== want.z) begin
            report_mismatch($sformatf("rot_z got %0d, want %0d", rot_z_i, want.z));
          end
          if (saturated_i !== want.sat) begin
            report_mismatch($sformatf("saturated got %0b, want %0b",
                                      saturated_i, want.sat));
          end
        end
        rot_beat_cnt++;
      end
      if (vec_valid_i && vec_ready_i) begin
        rotated_vec_q.push_back(rotate_vector(vec_x_i, vec_y_i, vec_z_i));
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[ADDR_W-1:2]))
          REG_QUAT_W: q_w = pwdata_i[QUAT_W-1:0];
          REG_QUAT_X: q_x = pwdata_i[QUAT_W-1:0];
          REG_QUAT_Y: q_y = pwdata_i[QUAT_W-1:0];
          REG_QUAT_Z: q_z = pwdata_i[QUAT_W-1:0];
          default: ;
        endcase
      end
    end
    pending_o = rotated_vec_q.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion vector rotation testbench
// Programs the quaternion over APB while the core is idle, then drives
// directed and random vec beats under three idling mixes on both channels.
// A checker beside the core predicts and compares every rot beat.
// ----------------------------------------------------------------------------
module tb_top;
  import qvr_pkg::*;

  localparam int CW           = COORD_WIDTH_DEF;
  localparam int LIMIT_CYCLES = 400000;
  localparam int SEGMENTS     = 6;
  localparam int SEG_ITEMS    = 64;
  localparam int TAIL_CYCLES  = 20;

  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW - 1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW - 1){1'b0}}};
  localparam logic [QUAT_W-1:0]    Q_ONE     = QUAT_W'(1 << QUAT_FRAC_BITS_DEF);
  localparam logic [QUAT_W-1:0]    Q_HALF    = QUAT_W'(1 << (QUAT_FRAC_BITS_DEF - 1));
  localparam logic [QUAT_W-1:0]    Q_POS_MAX = {1'b0, {(QUAT_W - 1){1'b1}}};
  localparam logic [QUAT_W-1:0]    Q_NEG_MAX = {1'b1, {(QUAT_W - 1){1'b0}}};
  localparam logic [QUAT_W-1:0]    Q_COS45   = QUAT_W'(11585);

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [DATA_W-1:0]     pwdata;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;
  logic                  vec_valid;
  logic                  vec_ready;
  logic signed [CW-1:0]  vec_x;
  logic signed [CW-1:0]  vec_y;
  logic signed [CW-1:0]  vec_z;
  logic                  rot_valid;
  logic                  rot_ready;
  logic signed [CW+1:0]  rot_x;
  logic signed [CW+1:0]  rot_y;
  logic signed [CW+1:0]  rot_z;
  logic                  saturated;
  int unsigned           err_count;
  int unsigned           pending;
  int                    tx_idle_pct;
  int                    rx_idle_pct;
  int                    cycle_cnt;

  quaternion_vector_rotate_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .vec_valid_i (vec_valid),
    .vec_ready_o (vec_ready),
    .vec_x_i     (vec_x),
    .vec_y_i     (vec_y),
    .vec_z_i     (vec_z),
    .rot_valid_o (rot_valid),
    .rot_ready_i (rot_ready),
    .rot_x_o     (rot_x),
    .rot_y_o     (rot_y),
    .rot_z_o     (rot_z),
    .saturated_o (saturated)
  );

  rot_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pready_i    (pready),
    .vec_valid_i (vec_valid),
    .vec_ready_i (vec_ready),
    .vec_x_i     (vec_x),
    .vec_y_i     (vec_y),
    .vec_z_i     (vec_z),
    .rot_valid_i (rot_valid),
    .rot_ready_i (rot_ready),
    .rot_x_i     (rot_x),
    .rot_y_i     (rot_y),
    .rot_z_i     (rot_z),
    .saturated_i (saturated),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  always @(negedge clk) begin
    rot_ready = ($urandom_range(0, 99) >= rx_idle_pct);
  end

  task automatic send_vec(input logic signed [CW-1:0] x,
                          input logic signed [CW-1:0] y,
                          input logic signed [CW-1:0] z);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      vec_valid = 1'b0;
      @(negedge clk);
    end
    vec_valid = 1'b1;
    vec_x     = x;
    vec_y     = y;
    vec_z     = z;
    @(posedge clk);
    while (!vec_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_rot;
    vec_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [QUAT_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {(DATA_W - QUAT_W)'($urandom), value};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_quat(input logic [QUAT_W-1:0] w, input logic [QUAT_W-1:0] x,
                          input logic [QUAT_W-1:0] y, input logic [QUAT_W-1:0] z);
    drain_rot();
    apb_write(REG_QUAT_W, w);
    apb_write(REG_QUAT_X, x);
    apb_write(REG_QUAT_Y, y);
    apb_write(REG_QUAT_Z, z);
  endtask

  function automatic logic signed [CW-1:0] pick_coord();
    case ($urandom_range(0, 9))
      6, 7: return CW'(int'($urandom_range(0, 16)) - 8);
      8: begin
        case ($urandom_range(0, 4))
          0: return COORD_MAX;
          1: return COORD_MIN;
          2: return '0;
          3: return '1;
          default: return CW'(1);
        endcase
      end
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic logic [QUAT_W-1:0] pick_quat_part(input int mode);
    case (mode)
      0: begin
        case ($urandom_range(0, 4))
          0: return Q_POS_MAX;
          1: return Q_NEG_MAX;
          2: return '0;
          3: return Q_ONE;
          default: return -Q_ONE;
        endcase
      end
      2, 5: return QUAT_W'(int'($urandom_range(0, 23170)) - 11585);
      3: return QUAT_W'(int'($urandom_range(0, 512)) - 256);
      default: return QUAT_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [QUAT_W-1:0] qw;
    rst_n       = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    vec_valid   = 1'b0;
    vec_x       = '0;
    vec_y       = '0;
    vec_z       = '0;
    rot_ready   = 1'b0;
    tx_idle_pct = 37;
    rx_idle_pct = 75;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Identity quaternion straight out of reset.
    send_vec(COORD_MAX, COORD_MIN, 0);
    send_vec(COORD_MIN, COORD_MAX, -1);
    send_vec(COORD_MAX, COORD_MAX, COORD_MAX);
    send_vec(COORD_MIN, COORD_MIN, COORD_MIN);
    send_vec(0, 0, 0);
    send_vec(1, -1, 12345);

    // A scale of one quarter puts exact halves on both signs.
    set_quat(Q_HALF, 0, 0, 0);
    send_vec(2, -2, 6);
    send_vec(-6, 1, -1);
    send_vec(3, -3, 5);

    set_quat(0, 0, 0, 0);
    send_vec(COORD_MAX, COORD_MIN, 1234);
    send_vec(COORD_MIN, COORD_MIN, COORD_MIN);

    // Most negative value on all four parts: each row scales one coordinate by sixteen.
    set_quat(Q_NEG_MAX, Q_NEG_MAX, Q_NEG_MAX, Q_NEG_MAX);
    send_vec(COORD_MAX, COORD_MIN, 1);
    send_vec(COORD_MIN, COORD_MIN, COORD_MIN);
    send_vec(1, 0, 0);

    set_quat(Q_POS_MAX, Q_POS_MAX, Q_POS_MAX, Q_POS_MAX);
    send_vec(COORD_MAX, COORD_MAX, COORD_MAX);
    send_vec(COORD_MIN, 1, -1);

    set_quat(Q_COS45, 0, 0, Q_COS45);
    send_vec(10000, 0, 0);
    send_vec(0, -10000, COORD_MAX);

    set_quat(Q_NEG_MAX, Q_POS_MAX, Q_NEG_MAX, Q_POS_MAX);
    send_vec(COORD_MAX, COORD_MIN, COORD_MAX);
    send_vec(100, -100, 7);

    for (int phase = 0; phase < 3; phase++) begin
      drain_rot();
      case (phase)
        0: begin
          tx_idle_pct = 37;
          rx_idle_pct = 75;
        end
        1: begin
          tx_idle_pct = 75;
          rx_idle_pct = 37;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        qw = pick_quat_part(seg);
        if (seg == 3) begin
          qw = qw + Q_ONE;
        end
        set_quat(qw, pick_quat_part(seg), pick_quat_part(seg), pick_quat_part(seg));
        for (int n = 0; n < SEG_ITEMS; n++) begin
          send_vec(pick_coord(), pick_coord(), pick_coord());
        end
      end
    end

    drain_rot();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
